>>> hdl/fqavsp_pkg.sv
// ----------------------------------------------------------------------------
// fqavsp_pkg
// Shared types and codes for the frame queue and A/V sync pacer.
// ----------------------------------------------------------------------------
package fqavsp_pkg;

  // result status codes
  localparam logic [1:0] ST_POSTED   = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  // input mode codes
  localparam logic MODE_POST = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PERIOD = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BUFFER_COUNT = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_RATE_TOL     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_TOL     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_COMPL_TICKS  = 3'd4;

  // register reset values
  localparam logic [9:0] FRAME_PERIOD_RST = 10'd40;
  localparam logic [3:0] BUFFER_COUNT_RST = 4'd3;
  localparam logic [7:0] RATE_TOL_RST     = 8'd2;
  localparam logic [7:0] SYNC_TOL_RST     = 8'd5;
  localparam logic [7:0] COMPL_TICKS_RST  = 8'd50;

  // timestamp that marks "no frame" or "unknown"
  localparam logic signed [63:0] NO_PTS = -64'sd1;

  typedef struct packed {
    logic               mode;
    logic signed [63:0] pts;
    logic signed [63:0] audio_pts;
    logic [15:0]        elapsed_ms;
    logic               paused;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         slot;
    logic signed [63:0] shown_pts;
    logic               frame_shown;
    logic signed [63:0] progress_pts;
    logic               progress_valid;
    logic               completed_event;
    logic signed [15:0] sleep_ms;
  } out_item_t;

endpackage

>>> hdl/fqavsp_ring.sv
// ----------------------------------------------------------------------------
// fqavsp_ring
// Timestamp ring store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fqavsp_ring #(
  parameter int unsigned DEPTH  = 8,
  parameter int unsigned ADDR_W = 3
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [63:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [63:0]       rdata_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/frame_queue_av_sync_pacer_unit.sv
// ----------------------------------------------------------------------------
// frame_queue_av_sync_pacer_unit
// Frame timestamp ring with render tick pacing and audio/video sync.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | input     | in_valid_i / in_ready_o  | fqavsp_pkg::in_item_t
//  out     | output    | out_valid_o / out_ready_i| fqavsp_pkg::out_item_t
//  cfg     | input     | cfg_we_i (no wait)       | cfg_addr_i, cfg_wdata_i
//
//  One item per cycle sustained while out_ready_i holds; each result is
//  registered with its ring read data, then passes the sync/pace stage
//  into the output register. Ring indices and fill count update at input
//  transfer; sync state updates as an active served tick leaves the second
//  stage. Reset is asynchronous and needs no clearing pass. A stalled output
//  holds both stages; a free second stage still takes one more item.
// ----------------------------------------------------------------------------
module frame_queue_av_sync_pacer_unit #(
  parameter int unsigned MAX_BUFFERS = 8
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  fqavsp_pkg::in_item_t                    in_data_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output fqavsp_pkg::out_item_t                   out_data_o,
  input  logic                                    cfg_we_i,
  input  logic [fqavsp_pkg::CFG_ADDR_W-1:0]       cfg_addr_i,
  input  logic [fqavsp_pkg::CFG_DATA_W-1:0]       cfg_wdata_i
);

  localparam int unsigned IDX_W = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned CW    = (CNT_W > 4) ? CNT_W : 4;
  localparam logic [CW-1:0] MAX_C = CW'(MAX_BUFFERS);

  // configuration registers
  logic [9:0] frame_period_q;
  logic [3:0] buffer_count_q;
  logic [7:0] rate_tol_q;
  logic [7:0] sync_tol_q;
  logic [7:0] compl_ticks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_period_q <= fqavsp_pkg::FRAME_PERIOD_RST;
      buffer_count_q <= fqavsp_pkg::BUFFER_COUNT_RST;
      rate_tol_q     <= fqavsp_pkg::RATE_TOL_RST;
      sync_tol_q     <= fqavsp_pkg::SYNC_TOL_RST;
      compl_ticks_q  <= fqavsp_pkg::COMPL_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        fqavsp_pkg::REG_FRAME_PERIOD: frame_period_q <= cfg_wdata_i;
        fqavsp_pkg::REG_BUFFER_COUNT: buffer_count_q <= cfg_wdata_i[3:0];
        fqavsp_pkg::REG_RATE_TOL:     rate_tol_q     <= cfg_wdata_i[7:0];
        fqavsp_pkg::REG_SYNC_TOL:     sync_tol_q     <= cfg_wdata_i[7:0];
        fqavsp_pkg::REG_COMPL_TICKS:  compl_ticks_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- stage 0
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CW-1:0]    bc_ext, used_slots, fill_ext;
  logic             ring_full, ring_empty;

  logic             adv, in_xfer, is_tick;
  logic             s1_valid_q;
  logic             mem_we, mem_re;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] idx,
                                                 input logic [CW-1:0] cnt);
    logic [CW:0] inc;
    inc = (CW+1)'(idx) + (CW+1)'(1);
    return (inc >= {1'b0, cnt}) ? '0 : IDX_W'(inc);
  endfunction

  assign bc_ext     = CW'(buffer_count_q);
  assign used_slots = (buffer_count_q == 4'd0) ? CW'(1) :
                      (bc_ext > MAX_C) ? MAX_C : bc_ext;
  assign fill_ext   = CW'(fill_q);
  assign ring_full  = (fill_ext >= used_slots);
  assign ring_empty = (fill_q == '0);

  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = !s1_valid_q || adv;
  assign in_xfer    = in_valid_i && in_ready_o;
  assign is_tick    = (in_data_i.mode == fqavsp_pkg::MODE_TICK);

  assign mem_we = in_xfer && !is_tick && !ring_full;
  assign mem_re = in_xfer && is_tick && !ring_empty;

  always_comb begin
    wr_idx_d = wr_idx_q;
    rd_idx_d = rd_idx_q;
    fill_d   = fill_q;
    if (mem_we) begin
      wr_idx_d = next_idx(wr_idx_q, used_slots);
      fill_d   = fill_q + CNT_W'(1);
    end else if (mem_re) begin
      rd_idx_d = next_idx(rd_idx_q, used_slots);
      fill_d   = fill_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q <= '0;
      rd_idx_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_idx_q <= wr_idx_d;
      rd_idx_q <= rd_idx_d;
      fill_q   <= fill_d;
    end
  end

  logic [63:0] ring_rdata;

  fqavsp_ring #(
    .DEPTH  (MAX_BUFFERS),
    .ADDR_W (IDX_W)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_idx_q),
    .wdata_i (in_data_i.pts),
    .re_i    (mem_re),
    .raddr_i (rd_idx_q),
    .rdata_o (ring_rdata)
  );

  // stage 1 carry registers
  logic [1:0]         s1_status_q;
  logic [2:0]         s1_slot_q;
  logic signed [63:0] s1_apts_q;
  logic [15:0]        s1_elapsed_q;
  logic               s1_paused_q;
  logic [IDX_W+2:0]   slot_ext;

  assign slot_ext = {3'b000, (is_tick ? rd_idx_q : wr_idx_q)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_status_q  <= is_tick ? (ring_empty ? fqavsp_pkg::ST_EMPTY : fqavsp_pkg::ST_SERVED)
                              : (ring_full ? fqavsp_pkg::ST_REJECTED : fqavsp_pkg::ST_POSTED);
      s1_slot_q    <= slot_ext[2:0];
      s1_apts_q    <= in_data_i.audio_pts;
      s1_elapsed_q <= in_data_i.elapsed_ms;
      s1_paused_q  <= in_data_i.paused;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic signed [63:0] last_audio_q, last_audio_d;
  logic signed [63:0] last_video_q, last_video_d;
  logic [7:0]         unchanged_q, unchanged_d;
  logic               completed_q, completed_d;
  logic signed [15:0] sleep_q, sleep_d;

  logic signed [63:0] vpts;
  logic               served, active, s1_update;
  logic               changed;
  logic [7:0]         unch_inc;
  logic signed [17:0] dev, tol_pos, tol_neg;
  logic signed [64:0] av_diff, st_pos, st_neg;
  logic signed [2:0]  delta;
  logic signed [16:0] sleep_sum;
  logic signed [15:0] sleep_sat;
  fqavsp_pkg::out_item_t out_d, out_q;
  logic               out_valid_q;

  assign vpts      = $signed(ring_rdata);
  assign served    = (s1_status_q == fqavsp_pkg::ST_SERVED);
  assign active    = !s1_paused_q && !completed_q;
  assign s1_update = adv && s1_valid_q && served && active;

  assign changed  = (last_audio_q != s1_apts_q) || (last_video_q != vpts);
  assign unch_inc = (unchanged_q == 8'hFF) ? unchanged_q : unchanged_q + 8'd1;

  assign dev     = $signed({2'b00, s1_elapsed_q}) - $signed({8'b0, frame_period_q});
  assign tol_pos = $signed({10'b0, rate_tol_q});
  assign tol_neg = -tol_pos;
  assign av_diff = $signed({s1_apts_q[63], s1_apts_q}) - $signed({vpts[63], vpts});
  assign st_pos  = $signed({57'b0, sync_tol_q});
  assign st_neg  = -st_pos;

  always_comb begin
    delta = 3'sd0;
    if (dev > tol_pos) delta = delta - 3'sd1;
    if (dev < tol_neg) delta = delta + 3'sd1;
    if ((s1_apts_q != fqavsp_pkg::NO_PTS) && (vpts != fqavsp_pkg::NO_PTS)) begin
      if (av_diff > st_pos) delta = delta - 3'sd2;
      else if (av_diff < st_neg) delta = delta + 3'sd2;
    end
  end

  assign sleep_sum = {sleep_q[15], sleep_q} + {{14{delta[2]}}, delta};
  assign sleep_sat = (sleep_sum > 17'sd32767)  ? 16'sh7FFF :
                     (sleep_sum < -17'sd32768) ? 16'sh8000 : sleep_sum[15:0];

  always_comb begin
    last_audio_d = last_audio_q;
    last_video_d = last_video_q;
    unchanged_d  = unchanged_q;
    completed_d  = completed_q;
    sleep_d      = sleep_q;

    out_d        = '0;
    out_d.status = s1_status_q;
    out_d.slot   = s1_slot_q;

    if (served) begin
      out_d.shown_pts   = vpts;
      out_d.frame_shown = (vpts != fqavsp_pkg::NO_PTS);
      if (!active) begin
        out_d.sleep_ms = $signed({6'b0, frame_period_q});
      end else begin
        out_d.progress_pts   = (vpts > s1_apts_q) ? vpts : s1_apts_q;
        out_d.progress_valid = 1'b1;
        if (changed) begin
          last_audio_d = s1_apts_q;
          last_video_d = vpts;
          unchanged_d  = 8'd0;
        end else begin
          unchanged_d = unch_inc;
          // compare after the increment; a zero target never matches
          if (unch_inc == compl_ticks_q) begin
            completed_d           = 1'b1;
            out_d.completed_event = 1'b1;
          end
        end
        sleep_d        = sleep_sat;
        out_d.sleep_ms = sleep_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_audio_q <= '0;
      last_video_q <= '0;
      unchanged_q  <= '0;
      completed_q  <= 1'b0;
      sleep_q      <= $signed({6'b0, fqavsp_pkg::FRAME_PERIOD_RST});
    end else if (s1_update) begin
      last_audio_q <= last_audio_d;
      last_video_q <= last_video_d;
      unchanged_q  <= unchanged_d;
      completed_q  <= completed_d;
      sleep_q      <= sleep_d;
    end
  end

  // output register: advance whenever the downstream side is free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/fqavsp_checker.sv
// ----------------------------------------------------------------------------
// fqavsp_checker
// Port-level checks on the result channel of the pacer, bound to the top.
// ----------------------------------------------------------------------------
module fqavsp_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input fqavsp_pkg::out_item_t out_data_o
);

  // hold a stalled result unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // progress only on a served tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.progress_valid |->
      out_data_o.status == fqavsp_pkg::ST_SERVED)
    else $error("progress raised on an item that is not a served tick");

  // completion is declared only on an active tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.completed_event |-> out_data_o.progress_valid)
    else $error("completion raised without progress");

  // posts and empty ticks carry nothing but status and slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != fqavsp_pkg::ST_SERVED |->
      out_data_o.shown_pts == '0 && !out_data_o.frame_shown &&
      out_data_o.sleep_ms == '0 && out_data_o.progress_pts == '0)
    else $error("unused result fields not cleared");

endmodule

bind frame_queue_av_sync_pacer_unit fqavsp_checker u_fqavsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
